### rtl/core/rgbba_pkg.sv
// ----------------------------------------------------------------------------
// rgbba_pkg
// Shared types, fixed-point coefficients and a clamp helper for the RGB565 brightness pipe.
// ----------------------------------------------------------------------------
package rgbba_pkg;

	// luma and chroma coefficients (Q10)
	localparam logic [17:0] C_YR = 18'd307;
	localparam logic [17:0] C_YG = 18'd604;
	localparam logic [17:0] C_YB = 18'd113;
	localparam logic signed [18:0] C_U = 19'sd505;
	localparam logic signed [18:0] C_V = 19'sd898;
	localparam logic signed [9:0] C_CHROMA_BIAS = 10'sd128;

	// reconstruction coefficients (Q12)
	localparam logic signed [24:0] C_RV = 25'sd5765;
	localparam logic signed [24:0] C_R_OFS = 25'sd737935;
	localparam logic signed [24:0] C_GU = 25'sd1415;
	localparam logic signed [24:0] C_GV = 25'sd2936;
	localparam logic signed [12:0] C_G_BIAS = 13'sd136;
	localparam logic signed [24:0] C_BU = 25'sd7287;
	localparam logic signed [24:0] C_B_OFS = 25'sd932708;

	// stage 1: expanded red and blue channels and luma
	typedef struct packed {
		logic [7:0] r;
		logic [7:0] b;
		logic [7:0] y;
	} luma_st_t;

	// stage 2: chroma and adjusted luma
	typedef struct packed {
		logic signed [9:0]  u;
		logic signed [9:0]  v;
		logic signed [10:0] ya;
		logic [7:0]         y;
	} chroma_st_t;

	// clamp a signed channel value to 0..255
	function automatic logic [7:0] clamp8(input logic signed [12:0] x);
		logic [7:0] res;
		if (x < 0) begin
			res = 8'd0;
		end else if (x > 13'sd255) begin
			res = 8'd255;
		end else begin
			res = x[7:0];
		end
		return res;
	endfunction

endpackage

### rtl/core/rgbba_luma.sv
// ----------------------------------------------------------------------------
// rgbba_luma
// Expands RGB565 to 8-bit channels and computes luma Y, one register stage.
// ----------------------------------------------------------------------------
module rgbba_luma (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [15:0]         pixel,
	output logic                out_valid,
	input  logic                out_ready,
	output rgbba_pkg::luma_st_t out_data
);

	logic               valid_s1;
	rgbba_pkg::luma_st_t data_s1;
	logic               en;
	logic [7:0]         r, g, b;
	logic [17:0]        ysum;

	assign en = !valid_s1 || out_ready;
	assign in_ready = en;

	assign r = {pixel[15:11], 3'b000};
	assign g = {pixel[10:5], 2'b00};
	assign b = {pixel[4:0], 3'b000};
	assign ysum = 18'(r) * rgbba_pkg::C_YR + 18'(g) * rgbba_pkg::C_YG
		+ 18'(b) * rgbba_pkg::C_YB;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en && in_valid) begin
			data_s1.r <= r;
			data_s1.b <= b;
			data_s1.y <= ysum[17:10];
		end
	end

	assign out_valid = valid_s1;
	assign out_data = data_s1;

endmodule

### rtl/core/rgbba_chroma.sv
// ----------------------------------------------------------------------------
// rgbba_chroma
// Derives U and V from luma and adds the brightness offset, one register stage.
// ----------------------------------------------------------------------------
module rgbba_chroma (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  rgbba_pkg::luma_st_t   in_data,
	input  logic signed [8:0]     offset,
	output logic                  out_valid,
	input  logic                  out_ready,
	output rgbba_pkg::chroma_st_t out_data
);

	logic                  valid_s2;
	rgbba_pkg::chroma_st_t data_s2;
	logic                  en;
	logic signed [9:0]     db, dr;
	logic signed [18:0]    pu, pv;

	assign en = !valid_s2 || out_ready;
	assign in_ready = en;

	assign db = $signed({2'b00, in_data.b}) - $signed({2'b00, in_data.y});
	assign dr = $signed({2'b00, in_data.r}) - $signed({2'b00, in_data.y});
	assign pu = 19'(db) * rgbba_pkg::C_U;
	assign pv = 19'(dr) * rgbba_pkg::C_V;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en && in_valid) begin
			data_s2.u  <= 10'(pu >>> 10) + rgbba_pkg::C_CHROMA_BIAS;
			data_s2.v  <= 10'(pv >>> 10) + rgbba_pkg::C_CHROMA_BIAS;
			// no clamp: adjusted luma may go negative
			data_s2.ya <= $signed({3'b000, in_data.y}) + 11'(offset);
			data_s2.y  <= in_data.y;
		end
	end

	assign out_valid = valid_s2;
	assign out_data = data_s2;

endmodule

### rtl/core/rgbba_recon.sv
// ----------------------------------------------------------------------------
// rgbba_recon
// Converts YUV back to RGB (sum stage), then clamps and repacks (pack stage).
// ----------------------------------------------------------------------------
module rgbba_recon (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  rgbba_pkg::chroma_st_t in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [15:0]           pixel,
	output logic [7:0]            luma
);

	logic               valid_s3, valid_s4;
	logic               en3, en4;
	logic signed [24:0] yq, ux, vx;
	logic signed [24:0] rsum_s3, gsum_s3, bsum_s3;
	logic [7:0]         y_s3;
	logic signed [12:0] rr, gg, bb;
	logic [7:0]         rc, gc, bc;
	logic [15:0]        pixel_s4;
	logic [7:0]         luma_s4;

	assign en4 = !valid_s4 || out_ready;
	assign en3 = !valid_s3 || en4;
	assign in_ready = en3;

	assign yq = 25'(in_data.ya) <<< 12;
	assign ux = 25'(in_data.u);
	assign vx = 25'(in_data.v);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (en3) begin
				valid_s3 <= in_valid;
			end
			if (en4) begin
				valid_s4 <= valid_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en3 && in_valid) begin
			rsum_s3 <= yq + vx * rgbba_pkg::C_RV - rgbba_pkg::C_R_OFS;
			gsum_s3 <= yq - ux * rgbba_pkg::C_GU - vx * rgbba_pkg::C_GV;
			bsum_s3 <= yq + ux * rgbba_pkg::C_BU - rgbba_pkg::C_B_OFS;
			y_s3    <= in_data.y;
		end
	end

	assign rr = 13'(rsum_s3 >>> 12);
	assign gg = 13'(gsum_s3 >>> 12) + rgbba_pkg::C_G_BIAS;
	assign bb = 13'(bsum_s3 >>> 12);
	assign rc = rgbba_pkg::clamp8(rr);
	assign gc = rgbba_pkg::clamp8(gg);
	assign bc = rgbba_pkg::clamp8(bb);

	always_ff @(posedge clk) begin
		if (en4 && valid_s3) begin
			pixel_s4 <= {rc[7:3], gc[7:2], bc[7:3]};
			luma_s4  <= y_s3;
		end
	end

	assign out_valid = valid_s4;
	assign pixel = pixel_s4;
	assign luma = luma_s4;

endmodule

### rtl/core/rgb565_brightness_adjust.sv
// Pipeline: luma, chroma, sum and pack register stages, in that order.
// Throughput: one pixel per clock while out_ready is held high; each stage has its own valid bit and advances
// whenever its downstream slot is free, so bubbles are squeezed out under stall.
// Reset: arst_n clears all stage valid bits and sets offset_q to 0.
// ----------------------------------------------------------------------------
// rgb565_brightness_adjust
// RGB565 brightness adjustment through a fixed-point YUV round trip.
// ----------------------------------------------------------------------------
module rgb565_brightness_adjust (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [15:0] pixel_in,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] pixel_out,
	output logic [7:0]  luma,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [8:0]  cfg_data
);

	logic signed [8:0]     offset_q;
	logic                  v1, r1, v2, r2;
	rgbba_pkg::luma_st_t   d1;
	rgbba_pkg::chroma_st_t d2;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= 9'sd0;
		end else if (cfg_valid) begin
			offset_q <= $signed(cfg_data);
		end
	end

	rgbba_luma u_luma (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.pixel     (pixel_in),
		.out_valid (v1),
		.out_ready (r1),
		.out_data  (d1)
	);

	rgbba_chroma u_chroma (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v1),
		.in_ready  (r1),
		.in_data   (d1),
		.offset    (offset_q),
		.out_valid (v2),
		.out_ready (r2),
		.out_data  (d2)
	);

	rgbba_recon u_recon (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v2),
		.in_ready  (r2),
		.in_data   (d2),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.pixel     (pixel_out),
		.luma      (luma)
	);

endmodule

### test/tb_rgb565_brightness_adjust.sv
// ----------------------------------------------------------------------------
// tb_rgb565_brightness_adjust
// Self-checking bench for the RGB565 brightness pipe. Pixels stream in through
// the input handshake, and a scoreboard predicts the adjusted pixel and the
// luma of each one. Every result is compared in order. Brightness settings
// change between phases, and both sides idle at random.
// ----------------------------------------------------------------------------
module tb_rgb565_brightness_adjust;

	localparam int PIPE_DEPTH   = 4;
	localparam int IDLE_LIMIT   = 1000;
	localparam int N_PHASES     = 10;
	localparam int PER_PHASE    = 155;

	typedef struct {
		logic [15:0] pixel;
		logic [7:0]  luma;
	} pixel_result_t;

	class pixel_scoreboard;
		pixel_result_t expected_q[$];
		int            offset;
		int            mismatches;
		int            checked;

		function new();
			offset = 0;
			mismatches = 0;
			checked = 0;
		endfunction

		function void set_offset(logic [8:0] raw);
			offset = int'($signed(raw));
		endfunction

		function logic [7:0] sat8(int x);
			logic [7:0] res;
			if (x < 0) begin
				res = 8'd0;
			end else if (x > 255) begin
				res = 8'd255;
			end else begin
				res = x[7:0];
			end
			return res;
		endfunction

		// YUV round trip with the current offset; >>> on int is a floor shift
		function pixel_result_t adjust_pixel(logic [15:0] px);
			pixel_result_t res;
			int r, g, b, y, u, v, ya;
			logic [7:0] r8, g8, b8;
			r = {px[15:11], 3'b000};
			g = {px[10:5], 2'b00};
			b = {px[4:0], 3'b000};
			y = (307 * r + 604 * g + 113 * b) >>> 10;
			u = ((505 * (b - y)) >>> 10) + 128;
			v = ((898 * (r - y)) >>> 10) + 128;
			ya = y + offset;
			r8 = sat8((ya * 4096 + 5765 * v - 737935) >>> 12);
			g8 = sat8(((ya * 4096 - 1415 * u - 2936 * v) >>> 12) + 136);
			b8 = sat8((ya * 4096 + 7287 * u - 932708) >>> 12);
			res.pixel = {r8[7:3], g8[7:2], b8[7:3]};
			res.luma = y[7:0];
			return res;
		endfunction

		function void note_pixel(logic [15:0] px);
			expected_q.push_back(adjust_pixel(px));
		endfunction

		function void check_result(logic [15:0] px, logic [7:0] y);
			pixel_result_t exp_r;
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected result pixel_out=%h luma=%h", $time, px, y);
				mismatches++;
			end else begin
				exp_r = expected_q.pop_front();
				checked++;
				if (px !== exp_r.pixel) begin
					$display("%0t: pixel_out mismatch: expected %h, actual %h",
						$time, exp_r.pixel, px);
					mismatches++;
				end
				if (y !== exp_r.luma) begin
					$display("%0t: luma mismatch: expected %h, actual %h",
						$time, exp_r.luma, y);
					mismatches++;
				end
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [15:0] pixel_in = 16'h0000;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [15:0] pixel_out;
	logic [7:0]  luma;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [8:0]  cfg_data = 9'd0;

	pixel_scoreboard sb;
	bit  burst_in = 1'b0;
	bit  burst_out = 1'b0;
	int  idle_cycles = 0;
	int  pixels_sent = 0;
	int  settings_used = 1;

	rgb565_brightness_adjust dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.pixel_in  (pixel_in),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.pixel_out (pixel_out),
		.luma      (luma),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// transaction monitor and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				sb.note_pixel(pixel_in);
			end
			if (out_valid && out_ready) begin
				sb.check_result(pixel_out, luma);
			end
			if (cfg_valid && cfg_ready) begin
				sb.set_offset(cfg_data);
			end
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	// result side: random back-pressure
	initial begin
		int stall;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = burst_out ? 0 : $urandom_range(0, 6);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	task automatic send_pixel(input logic [15:0] px);
		int gap;
		gap = burst_in ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		pixel_in <= px;
		pixels_sent++;
		do @(posedge clk); while (!in_ready);
	endtask

	// stop feeding, let every result come back, then let the pipe settle
	task automatic drain_pipe();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (PIPE_DEPTH + 2) @(posedge clk);
	endtask

	task automatic write_offset(input int val);
		cfg_valid <= 1'b1;
		cfg_data <= val[8:0];
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [15:0] random_pixel();
		logic [15:0] px;
		case ($urandom_range(0, 7))
			0: px = {$urandom_range(0, 1) ? 5'h1f : 5'h00,
				$urandom_range(0, 1) ? 6'h3f : 6'h00,
				$urandom_range(0, 1) ? 5'h1f : 5'h00};
			default: px = 16'($urandom_range(0, 65535));
		endcase
		return px;
	endfunction

	initial begin
		logic [15:0] corner_px[15];
		int offsets[N_PHASES];
		corner_px = '{16'h0000, 16'hffff, 16'hf800, 16'h07e0, 16'h001f, 16'h0001, 16'h0020,
			16'h0800, 16'h7bef, 16'h8410, 16'hf81f, 16'hffe0, 16'h07ff, 16'h5555, 16'haaaa};
		// extremes of the 9-bit range, including -256, plus a few in between
		offsets = '{255, -256, -255, 0, 1, -1, 128, -128, 0, 0};
		offsets[8] = $urandom_range(0, 510) - 255;
		offsets[9] = $urandom_range(0, 510) - 255;
		sb = new();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// corners at the reset offset
		foreach (corner_px[i]) begin
			send_pixel(corner_px[i]);
		end

		foreach (offsets[p]) begin
			drain_pipe();
			write_offset(offsets[p]);
			settings_used++;
			burst_in = ($urandom_range(0, 3) == 0);
			burst_out = ($urandom_range(0, 3) == 0);
			repeat (PER_PHASE) begin
				send_pixel(random_pixel());
			end
		end

		drain_pipe();
		$display("Sent %0d pixels across %0d brightness settings (both extremes included).",
			pixels_sent, settings_used);
		$display("Checked %0d results, %0d mismatches.", sb.checked, sb.mismatches);
		if (sb.mismatches == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

### filelist.f
rtl/core/rgbba_pkg.sv
rtl/core/rgbba_luma.sv
rtl/core/rgbba_chroma.sv
rtl/core/rgbba_recon.sv
rtl/core/rgb565_brightness_adjust.sv
test/tb_rgb565_brightness_adjust.sv
